// ----- rtl/core/stepper_dose_retract_ramp_defines.svh -----
// ----------------------------------------------------------------------------
// stepper dose retract ramp: assertion macros
// shared concurrent assertion forms for the dose sequencer modules
// ----------------------------------------------------------------------------
`ifndef STEPPER_DOSE_RETRACT_RAMP_DEFINES_SVH
`define STEPPER_DOSE_RETRACT_RAMP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SDR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SDR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sdr_pkg.sv -----
// ----------------------------------------------------------------------------
// sdr_pkg
// widths, phase codes, register indexes and controller/datapath interface
// ----------------------------------------------------------------------------
package sdr_pkg;

    // default step counter width
    localparam int STEP_COUNT_BITS_DEF = 20;

    // fixed field widths
    localparam int PERIOD_BITS    = 16;
    localparam int RAMP_BITS      = 16;
    localparam int RETRACT_BITS   = 20;
    localparam int FWD_BITS       = 20;
    localparam int DONE_OUT_BITS  = 20;
    localparam int PHASE_BITS     = 3;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_DATA_BITS  = 20;
    localparam int IN_TDATA_BITS  = 24;
    localparam int OUT_TDATA_BITS = 32;
    localparam int CMP_BITS       = 33;

    // move phase codes
    typedef logic [PHASE_BITS-1:0] t_phase;
    localparam t_phase PH_IDLE = 3'd0;
    localparam t_phase PH_FACC = 3'd1;
    localparam t_phase PH_FRUN = 3'd2;
    localparam t_phase PH_FDEC = 3'd3;
    localparam t_phase PH_RACC = 3'd4;
    localparam t_phase PH_RRUN = 3'd5;
    localparam t_phase PH_RDEC = 3'd6;

    // configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_RETRACT_STEPS = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RAMP_FWD      = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RAMP_RET      = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PMIN_FWD      = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PMAX_FWD      = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PMIN_RET      = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PMAX_RET      = 3'd6;

    // configuration reset values
    localparam logic [RETRACT_BITS-1:0] RST_RETRACT_STEPS = 20'd100;
    localparam logic [RAMP_BITS-1:0]    RST_RAMP          = 16'd200;
    localparam logic [PERIOD_BITS-1:0]  RST_PMIN          = 16'd200;
    localparam logic [PERIOD_BITS-1:0]  RST_PMAX          = 16'd1000;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic step;
        logic opnd;
        logic mul;
        logic upd;
        logic load_fwd;
        logic load_ret;
        logic div_start;
        logic slope_load;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic func;
        logic start_ok;
        logic phase_idle;
        logic begin_ret;
        logic div_done;
    } t_sts;

endpackage

// ----- rtl/core/sdr_div.sv -----
// ----------------------------------------------------------------------------
// sdr_div
// restoring divider for the per-move ramp slope, one quotient bit a cycle
// ----------------------------------------------------------------------------
module sdr_div import sdr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [PERIOD_BITS-1:0] i_dividend,
    input  logic [RAMP_BITS-1:0]   i_divisor,
    output logic [PERIOD_BITS-1:0] o_quot,
    output logic                   o_done
);

    localparam int DIV_STEPS = PERIOD_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;
    logic [RAMP_BITS-1:0]   r_rem, n_rem;
    logic [PERIOD_BITS-1:0] r_quot, n_quot;
    logic [RAMP_BITS-1:0]   r_divisor, n_divisor;
    logic [RAMP_BITS:0]     w_rem_sh;
    logic                   w_fits;
    logic [RAMP_BITS:0]     w_rem_nx;

    // one trial subtraction
    assign w_rem_sh = {r_rem, r_quot[PERIOD_BITS-1]};
    assign w_fits   = w_rem_sh >= {1'b0, r_divisor};
    assign w_rem_nx = w_fits ? (w_rem_sh - {1'b0, r_divisor}) : w_rem_sh;

    // iteration sequencing
    always_comb begin
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_quot    = r_quot;
        n_divisor = r_divisor;
        if (i_start) begin
            n_busy    = 1'b1;
            n_cnt     = '0;
            n_rem     = '0;
            n_quot    = i_dividend;
            n_divisor = i_divisor;
        end else if (r_busy) begin
            n_rem  = w_rem_nx[RAMP_BITS-1:0];
            n_quot = {r_quot[PERIOD_BITS-2:0], w_fits};
            n_cnt  = r_cnt + CNT_BITS'(1);
            if (r_cnt == CNT_BITS'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // operand and partial result registers
    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_rem     <= n_rem;
        r_quot    <= n_quot;
        r_divisor <= n_divisor;
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

// ----- rtl/core/sdr_ctrl.sv -----
// ----------------------------------------------------------------------------
// sdr_ctrl
// item sequencer: steps each transfer through the datapath and the output register
// ----------------------------------------------------------------------------
`include "stepper_dose_retract_ramp_defines.svh"

module sdr_ctrl import sdr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_WAIT  = 9'b000000001,
        S_EXEC  = 9'b000000010,
        S_OPND  = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_UPD   = 9'b000010000,
        S_LOAD  = 9'b000100000,
        S_DIVGO = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   w_cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_WAIT: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.func) begin
                    if (i_sts.start_ok) begin
                        w_cmd.load_fwd = 1'b1;
                        n_state        = S_DIVGO;
                    end else begin
                        n_state = S_OUT;
                    end
                end else if (i_sts.phase_idle) begin
                    n_state = S_OUT;
                end else begin
                    w_cmd.step = 1'b1;
                    n_state    = S_OPND;
                end
            end
            S_OPND: begin
                w_cmd.opnd = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                w_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                w_cmd.upd = 1'b1;
                n_state   = i_sts.begin_ret ? S_LOAD : S_OUT;
            end
            S_LOAD: begin
                w_cmd.load_ret = 1'b1;
                n_state        = S_DIVGO;
            end
            S_DIVGO: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    w_cmd.slope_load = 1'b1;
                    n_state          = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_WAIT;
                end
            end
            default: n_state = S_WAIT;
        endcase
    end

    // output register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WAIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_WAIT);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    // one item in flight at a time
    `SDR_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second transfer taken while an item is in flight")
    // the divider finishes only while the sequencer waits for it
    `SDR_ASSERT_NOW(a_div_wait, i_clk, i_rst_n, i_sts.div_done, r_state == S_DIV, "divider finished outside the slope wait")
    // a result is loaded only into a free or draining output register
    `SDR_ASSERT_NOW(a_out_free, i_clk, i_rst_n, w_cmd.out_load && r_out_valid, i_out_ready, "result overwritten before transfer")

endmodule

// ----- rtl/core/sdr_dpath.sv -----
// ----------------------------------------------------------------------------
// sdr_dpath
// configuration, move state, step timing, ramp period arithmetic and result register
// ----------------------------------------------------------------------------
`include "stepper_dose_retract_ramp_defines.svh"

module sdr_dpath import sdr_pkg::*; #(
    parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,
    input  logic                      i_in_func,
    input  logic [FWD_BITS-1:0]       i_in_fwd,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    output logic [OUT_TDATA_BITS-1:0] o_out_tdata
);

    localparam int W  = STEP_COUNT_BITS;
    localparam int PW = PERIOD_BITS + W;

    // configuration registers
    logic [RETRACT_BITS-1:0] r_cfg_retract;
    logic [RAMP_BITS-1:0]    r_cfg_ramp_fwd, r_cfg_ramp_ret;
    logic [PERIOD_BITS-1:0]  r_cfg_pmin_fwd, r_cfg_pmax_fwd;
    logic [PERIOD_BITS-1:0]  r_cfg_pmin_ret, r_cfg_pmax_ret;

    // captured item
    logic         r_func, n_func;
    logic [W-1:0] r_fwd, n_fwd;

    // move state
    t_phase                 r_phase, n_phase;
    logic [W-1:0]           r_total, n_total;
    logic [RAMP_BITS-1:0]   r_ramp, n_ramp;
    logic [W-1:0]           r_done, n_done;
    logic [PERIOD_BITS-1:0] r_period, n_period;
    logic [PERIOD_BITS-1:0] r_tick, n_tick;
    logic [PERIOD_BITS-1:0] r_slope, n_slope;
    logic [PERIOD_BITS-1:0] r_pmin, n_pmin;
    logic [PERIOD_BITS-1:0] r_pmax, n_pmax;
    logic [W-1:0]           r_base, n_base;
    logic [W-1:0]           r_opnd, n_opnd;
    logic [PW-1:0]          r_prod, n_prod;

    // result bits gathered while the item runs
    logic                      r_res_acc, n_res_acc;
    logic                      r_res_pulse, n_res_pulse;
    logic                      r_res_dir, n_res_dir;
    logic [OUT_TDATA_BITS-1:0] r_out_tdata, n_out_tdata;

    logic                     w_is_acc, w_is_ret, w_running, w_tick_hit, w_busy;
    logic [W-1:0]             w_ld_total;
    logic [RAMP_BITS-1:0]     w_ld_cfg_ramp, w_ld_ramp;
    logic [PERIOD_BITS-1:0]   w_ld_lo, w_ld_hi;
    logic [W-1:0]             w_base, w_opnd;
    logic [PERIOD_BITS-1:0]   w_acc_period, w_dec_period;
    logic [PW:0]              w_dec_sum;
    logic                     w_reach_run, w_reach_dec, w_ramp_on;
    t_phase                   w_upd_phase;
    logic [PERIOD_BITS-1:0]   w_upd_period;
    logic                     w_begin_ret, w_move_end;
    logic [PERIOD_BITS-1:0]   w_span;
    logic [PERIOD_BITS-1:0]   w_quot;
    logic                     w_div_done;
    logic [DONE_OUT_BITS-1:0] w_steps_out;
    logic [CMP_BITS-1:0]      w_ramp_dbl;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_retract  <= RST_RETRACT_STEPS;
            r_cfg_ramp_fwd <= RST_RAMP;
            r_cfg_ramp_ret <= RST_RAMP;
            r_cfg_pmin_fwd <= RST_PMIN;
            r_cfg_pmax_fwd <= RST_PMAX;
            r_cfg_pmin_ret <= RST_PMIN;
            r_cfg_pmax_ret <= RST_PMAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_RETRACT_STEPS: r_cfg_retract  <= i_cfg_wdata[RETRACT_BITS-1:0];
                REG_RAMP_FWD:      r_cfg_ramp_fwd <= i_cfg_wdata[RAMP_BITS-1:0];
                REG_RAMP_RET:      r_cfg_ramp_ret <= i_cfg_wdata[RAMP_BITS-1:0];
                REG_PMIN_FWD:      r_cfg_pmin_fwd <= i_cfg_wdata[PERIOD_BITS-1:0];
                REG_PMAX_FWD:      r_cfg_pmax_fwd <= i_cfg_wdata[PERIOD_BITS-1:0];
                REG_PMIN_RET:      r_cfg_pmin_ret <= i_cfg_wdata[PERIOD_BITS-1:0];
                REG_PMAX_RET:      r_cfg_pmax_ret <= i_cfg_wdata[PERIOD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // phase decode
    assign w_is_acc  = (r_phase == PH_FACC) || (r_phase == PH_RACC);
    assign w_is_ret  = (r_phase == PH_RACC) || (r_phase == PH_RRUN) || (r_phase == PH_RDEC);
    assign w_busy    = (r_phase != PH_IDLE);
    assign w_running = r_done < r_total;
    assign w_tick_hit = ((PERIOD_BITS+1)'(r_tick) + (PERIOD_BITS+1)'(1))
                        >= (PERIOD_BITS+1)'(r_period);

    // move load: pick direction, clip ramp to half the move
    assign w_ld_total    = i_cmd.load_fwd ? r_fwd : W'(r_cfg_retract);
    assign w_ld_cfg_ramp = i_cmd.load_fwd ? r_cfg_ramp_fwd : r_cfg_ramp_ret;
    assign w_ld_lo       = i_cmd.load_fwd ? r_cfg_pmin_fwd : r_cfg_pmin_ret;
    assign w_ld_hi       = i_cmd.load_fwd ? r_cfg_pmax_fwd : r_cfg_pmax_ret;
    assign w_ld_ramp     = (CMP_BITS'(w_ld_total) < CMP_BITS'({w_ld_cfg_ramp, 1'b0}))
                           ? RAMP_BITS'(w_ld_total >> 1) : w_ld_cfg_ramp;

    // deceleration start point and ramp multiplier operand
    assign w_base = (CMP_BITS'(r_total) >= CMP_BITS'(r_ramp)) ? (r_total - W'(r_ramp)) : '0;
    assign w_opnd = w_is_acc ? r_done : ((r_done >= r_base) ? (r_done - r_base) : '0);

    // period from the registered product
    assign w_acc_period = (r_prod >= PW'(r_pmax)) ? '0 : (r_pmax - r_prod[PERIOD_BITS-1:0]);
    assign w_dec_sum    = (PW+1)'(r_pmin) + (PW+1)'(r_prod);
    assign w_dec_period = (|w_dec_sum[PW:PERIOD_BITS]) ? '1 : w_dec_sum[PERIOD_BITS-1:0];

    assign w_reach_run = CMP_BITS'(r_done) >= CMP_BITS'(r_ramp);
    assign w_reach_dec = (CMP_BITS'(r_done) + CMP_BITS'(r_ramp)) >= CMP_BITS'(r_total);
    assign w_ramp_on   = (r_ramp != '0);

    // ramp and phase update after a step
    always_comb begin
        w_upd_phase  = r_phase;
        w_upd_period = r_period;
        unique case (r_phase) inside
            PH_FACC, PH_RACC: begin
                if (w_ramp_on) begin
                    w_upd_period = w_acc_period;
                end
                if (w_reach_run) begin
                    w_upd_phase = (r_phase == PH_FACC) ? PH_FRUN : PH_RRUN;
                end
            end
            PH_FRUN, PH_RRUN: begin
                if (w_reach_dec) begin
                    w_upd_phase = (r_phase == PH_FRUN) ? PH_FDEC : PH_RDEC;
                end
            end
            PH_FDEC, PH_RDEC: begin
                if (w_ramp_on) begin
                    w_upd_period = w_dec_period;
                end
            end
            default: ;
        endcase
    end

    assign w_begin_ret = ((w_upd_phase == PH_FRUN) || (w_upd_phase == PH_FDEC)) && !w_running;
    assign w_move_end  = ((w_upd_phase == PH_RRUN) || (w_upd_phase == PH_RDEC)) && !w_running;

    // slope divider
    assign w_span = r_pmax - r_pmin;

    sdr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_span),
        .i_divisor  (r_ramp),
        .o_quot     (w_quot),
        .o_done     (w_div_done)
    );

    assign w_steps_out = w_busy ? DONE_OUT_BITS'(r_done) : '0;

    // next values under the sequencer's commands
    always_comb begin
        n_func      = r_func;
        n_fwd       = r_fwd;
        n_phase     = r_phase;
        n_total     = r_total;
        n_ramp      = r_ramp;
        n_done      = r_done;
        n_period    = r_period;
        n_tick      = r_tick;
        n_slope     = r_slope;
        n_pmin      = r_pmin;
        n_pmax      = r_pmax;
        n_base      = r_base;
        n_opnd      = r_opnd;
        n_prod      = r_prod;
        n_res_acc   = r_res_acc;
        n_res_pulse = r_res_pulse;
        n_res_dir   = r_res_dir;
        n_out_tdata = r_out_tdata;

        if (i_cmd.capture) begin
            n_func      = i_in_func;
            n_fwd       = W'(i_in_fwd);
            n_res_acc   = 1'b0;
            n_res_pulse = 1'b0;
            n_res_dir   = 1'b0;
        end

        if (i_cmd.load_fwd || i_cmd.load_ret) begin
            n_total  = w_ld_total;
            n_ramp   = w_ld_ramp;
            n_pmin   = w_ld_lo;
            n_pmax   = w_ld_hi;
            n_period = w_ld_hi;
            n_done   = '0;
            n_tick   = '0;
            n_slope  = '0;
            if (i_cmd.load_fwd) begin
                n_res_acc = 1'b1;
                n_phase   = (w_ld_ramp != '0) ? PH_FACC : PH_FRUN;
            end else begin
                n_phase   = (w_ld_ramp != '0) ? PH_RACC : PH_RRUN;
            end
        end

        // tick counting and step issue
        if (i_cmd.step) begin
            n_res_dir = w_is_ret;
            if (w_running) begin
                if (w_tick_hit) begin
                    n_tick      = '0;
                    n_done      = r_done + W'(1);
                    n_res_pulse = 1'b1;
                end else begin
                    n_tick = r_tick + PERIOD_BITS'(1);
                end
            end
        end

        if (i_cmd.opnd) begin
            n_opnd = w_opnd;
        end

        if (i_cmd.mul) begin
            n_prod = PW'(r_slope) * PW'(r_opnd);
        end

        if (i_cmd.upd) begin
            n_period = w_upd_period;
            n_phase  = w_move_end ? PH_IDLE : w_upd_phase;
        end

        if (i_cmd.div_start) begin
            n_base = w_base;
        end

        if (i_cmd.slope_load) begin
            n_slope = (w_ramp_on && (r_pmax >= r_pmin)) ? w_quot : '0;
        end

        // result word, highest field first
        if (i_cmd.out_load) begin
            n_out_tdata = {
                (OUT_TDATA_BITS - DONE_OUT_BITS - PHASE_BITS - 4)'(0),
                w_steps_out,
                r_phase,
                w_busy,
                r_res_dir,
                r_res_pulse,
                r_res_acc
            };
        end
    end

    // control and move state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_total  <= '0;
            r_ramp   <= '0;
            r_done   <= '0;
            r_period <= '0;
            r_tick   <= '0;
            r_slope  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_total  <= n_total;
            r_ramp   <= n_ramp;
            r_done   <= n_done;
            r_period <= n_period;
            r_tick   <= n_tick;
            r_slope  <= n_slope;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_fwd       <= n_fwd;
        r_pmin      <= n_pmin;
        r_pmax      <= n_pmax;
        r_base      <= n_base;
        r_opnd      <= n_opnd;
        r_prod      <= n_prod;
        r_res_acc   <= n_res_acc;
        r_res_pulse <= n_res_pulse;
        r_res_dir   <= n_res_dir;
        r_out_tdata <= n_out_tdata;
    end

    // status to the sequencer
    assign o_sts.func       = r_func;
    assign o_sts.start_ok   = (r_phase == PH_IDLE) && (r_fwd != '0)
                              && (W'(r_cfg_retract) != '0);
    assign o_sts.phase_idle = (r_phase == PH_IDLE);
    assign o_sts.begin_ret  = w_begin_ret;
    assign o_sts.div_done   = w_div_done;

    assign o_out_tdata = r_out_tdata;

    assign w_ramp_dbl = CMP_BITS'({r_ramp, 1'b0});

    // steps never run past the move length
    `SDR_ASSERT_NOW(a_done_bound, i_clk, i_rst_n, w_busy, r_done <= r_total, "step count passed move length")
    // ramp length is clipped to half the move
    `SDR_ASSERT_NOW(a_ramp_half, i_clk, i_rst_n, w_busy, w_ramp_dbl <= CMP_BITS'(r_total), "ramp longer than half the move")

endmodule

// ----- rtl/core/stepper_dose_retract_ramp.sv -----
// ----------------------------------------------------------------------------
// stepper_dose_retract_ramp
// two-phase stepper dose sequencer with trapezoidal forward and retract moves
// ----------------------------------------------------------------------------
// channel     dir  transfer on                    payload
// s_axis      in   s_axis_tvalid & s_axis_tready  tuser: func; tdata: forward_steps
// m_axis      out  m_axis_tvalid & m_axis_tready  tdata: status word, one per item
// cfg         in   i_cfg_we                       i_cfg_addr selects, i_cfg_wdata value
//
// a tick outside a move or a rejected start goes from capture straight to the result register
// a tick during a move runs count, operand, multiply, period update, result in turn
// a dose start, or the tick that ends the forward move, adds a restoring divide
// for the move slope before the result
// synchronous reset returns configuration to its defaults and the phase to idle
// the next item is taken while a result still waits on m_axis_tready
// ----------------------------------------------------------------------------
module stepper_dose_retract_ramp import sdr_pkg::*; #(
    parameter int STEP_COUNT_BITS = STEP_COUNT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,
    // item input
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,  // [19:0] forward_steps, [23:20] zero
    input  logic                      s_axis_tuser,  // [0] func
    // result output
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata   // [0] accepted, [1] step_pulse,
                                                     // [2] direction, [3] busy_res,
                                                     // [6:4] phase, [26:7] steps_done,
                                                     // [31:27] zero
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    sdr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // move state and arithmetic
    sdr_dpath #(
        .STEP_COUNT_BITS (STEP_COUNT_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_func   (s_axis_tuser),
        .i_in_fwd    (s_axis_tdata[FWD_BITS-1:0]),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_tdata (m_axis_tdata)
    );

endmodule
